>>> hw/rtl/msc_pkg.sv
// Shared types, character codes and the Morse symbol ROM of the Morse codec.
`timescale 1ns / 1ps
`default_nettype none
package msc_pkg;

	localparam int CharW          = 8;
	localparam int RunDepth       = 6;
	localparam int TableSize      = 36;
	localparam int MaxCodeSymbols = 7;

	typedef logic [CharW-1:0] char_t;
	typedef logic [2:0]       cnt_t;
	typedef logic [5:0]       tidx_t;

	localparam char_t CharDot   = 8'h2E;
	localparam char_t CharDash  = 8'h2D;
	localparam char_t CharSpace = 8'h20;
	localparam char_t CharSlash = 8'h2F;
	localparam char_t CharQuery = 8'h3F;

	localparam logic DirEncode = 1'b0;
	localparam logic DirDecode = 1'b1;

	// Pending decode code.
	typedef struct packed {
		logic [6:0] pattern;
		logic [2:0] length;
		logic       nonempty;
		logic       invalid;
	} pend_t;

	// Results caused by one input transaction.
	typedef struct packed {
		char_t [RunDepth-1:0] chars;
		cnt_t                 count;
	} run_t;

	// Entries A-Z then 0-9: length in [10:8], dash mask in [6:0].
	localparam logic [15:0] SymbolTable [TableSize] = '{
		16'h0202, 16'h0401, 16'h0405, 16'h0301, 16'h0100, 16'h0404,
		16'h0303, 16'h0400, 16'h0200, 16'h040E, 16'h0305, 16'h0402,
		16'h0203, 16'h0201, 16'h0307, 16'h0406, 16'h040B, 16'h0302,
		16'h0300, 16'h0101, 16'h0304, 16'h0408, 16'h0306, 16'h0409,
		16'h040D, 16'h0403,
		16'h051F, 16'h051E, 16'h051C, 16'h0518, 16'h0510,
		16'h0500, 16'h0501, 16'h0503, 16'h0507, 16'h050F
	};

	// Table index of a text character after case folding, TableSize if none.
	function automatic tidx_t char_index(input char_t c);
		char_t u;
		tidx_t r;
		u = c;
		r = tidx_t'(TableSize);
		if (c >= 8'h61 && c <= 8'h7A) begin
			u = c - 8'd32;
		end
		if (u >= 8'h41 && u <= 8'h5A) begin
			r = tidx_t'(u - 8'h41);
		end else if (u >= 8'h30 && u <= 8'h39) begin
			r = tidx_t'(u - 8'h30) + tidx_t'(26);
		end
		return r;
	endfunction

	// Character for a pending code, '?' when invalid or unmatched.
	function automatic char_t decode_code(input pend_t p);
		char_t r;
		r = CharQuery;
		if (!p.invalid) begin
			for (int i = 0; i < TableSize; i++) begin
				if (SymbolTable[i][10:8] == p.length && SymbolTable[i][6:0] == p.pattern) begin
					r = (i < 26) ? char_t'(8'h41 + i) : char_t'(8'h30 + i - 26);
				end
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/msc_in_if.sv
// Input channel of the Morse codec: one character per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface msc_in_if;
	logic             valid;
	logic             ready;
	msc_pkg::char_t   in_char;
	logic             end_of_text;

	modport source (output valid, output in_char, output end_of_text, input ready);
	modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/msc_out_if.sv
// Output channel of the Morse codec: one result character per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface msc_out_if;
	logic             valid;
	logic             ready;
	msc_pkg::char_t   out_char;
	logic             last_of_run;

	modport source (output valid, output out_char, output last_of_run, input ready);
	modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/msc_step.sv
// Per-character encode/decode logic: builds the result run and next pending code.
`timescale 1ns / 1ps
`default_nettype none
module msc_step (
	input  wire               direction,
	input  msc_pkg::char_t    in_char,
	input  wire               end_of_text,
	input  msc_pkg::pend_t    pend_cur,
	output msc_pkg::pend_t    pend_nxt,
	output msc_pkg::run_t     run
);
	import msc_pkg::*;

	tidx_t      idx;
	logic [2:0] sym_len;
	logic [6:0] sym_pat;
	pend_t      p;
	cnt_t       n;

	assign idx     = char_index(in_char);
	assign sym_len = (idx < tidx_t'(TableSize)) ? SymbolTable[idx][10:8] : 3'd0;
	assign sym_pat = (idx < tidx_t'(TableSize)) ? SymbolTable[idx][6:0] : 7'd0;

	always_comb begin
		p         = pend_cur;
		n         = '0;
		run.chars = '{default: CharSpace};
		if (direction == DirEncode) begin
			// Encode: symbols or '/', then a separator unless the text ends here; '?' alone for other characters
			if (idx < tidx_t'(TableSize)) begin
				for (int i = 0; i < 5; i++) begin
					if (3'(i) < sym_len) begin
						run.chars[i] = sym_pat[i] ? CharDash : CharDot;
					end
				end
				n = sym_len + cnt_t'(!end_of_text);
			end else if (in_char == CharSpace) begin
				run.chars[0] = CharSlash;
				n            = end_of_text ? 3'd1 : 3'd2;
			end else begin
				run.chars[0] = CharQuery;
				n            = 3'd1;
			end
		end else begin
			// Decode: word break, flush on space, or gather a symbol
			if (in_char == CharSlash) begin
				run.chars[0] = CharSpace;
				n            = 3'd1;
			end else if (in_char == CharSpace) begin
				if (p.nonempty) begin
					run.chars[0] = decode_code(p);
					n            = 3'd1;
					p            = '0;
				end
			end else begin
				p.nonempty = 1'b1;
				if (p.length >= 3'(MaxCodeSymbols)) begin
					p.invalid = 1'b1;
				end else begin
					if (in_char == CharDash) begin
						p.pattern = p.pattern | (7'd1 << p.length);
					end else if (in_char != CharDot) begin
						p.invalid = 1'b1;
					end
					p.length = p.length + 3'd1;
				end
			end
			// End of text flushes whatever is still pending
			if (end_of_text && p.nonempty) begin
				run.chars[n] = decode_code(p);
				n            = n + 3'd1;
				p            = '0;
			end
		end
		run.count = n;
		pend_nxt  = p;
	end

endmodule
`default_nettype wire

>>> hw/rtl/morse_codec_stream_unit.sv
// Top level of the byte-stream Morse codec with APB configuration port.
//
// Usage: text or Morse bytes enter on din (valid/ready); each accepted
// transaction yields zero to six result characters on dout, the last one
// flagged with last_of_run. Register 0 (byte address 0), bit 0, selects
// the direction: 0 encodes text to dots and dashes, 1 decodes them back.
// Write it only while no results are outstanding.
// The first result of a transaction passes through the run buffer and the
// output register before it is presented on dout. Results then leave one
// per cycle from the run buffer while dout is ready: up to six for an
// encoded character, at most two in decode. The next transaction is
// taken in the cycle the run buffer hands over its last character.
// Reset clears the direction (encode), the pending decode code, the run
// buffer count and the output valid flag. When dout stalls, the output
// register holds its character, the run buffer stops draining and din
// deasserts ready while the buffer holds any character.
`timescale 1ns / 1ps
`default_nettype none
module morse_codec_stream_unit (
	input  wire          clk,
	input  wire          arst_n,
	msc_in_if.sink       din,
	msc_out_if.source    dout,
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [2:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import msc_pkg::*;

	localparam logic RegDirection = 1'b0;

	logic                 dir_q;
	pend_t                pend_q;
	pend_t                pend_nxt;
	run_t                 run;
	char_t [RunDepth-1:0] chars_q;
	cnt_t                 rem_q;
	logic                 out_valid_q;
	char_t                out_char_q;
	logic                 out_last_q;
	logic                 acc;
	logic                 pop;
	logic                 cfg_wr;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == RegDirection) ? {31'd0, dir_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DirEncode;
		end else if (cfg_wr && paddr[2] == RegDirection) begin
			dir_q <= pwdata[0];
		end
	end

	msc_step u_step (
		.direction   (dir_q),
		.in_char     (din.in_char),
		.end_of_text (din.end_of_text),
		.pend_cur    (pend_q),
		.pend_nxt    (pend_nxt),
		.run         (run)
	);

	// Handshake: drain the run buffer into the output register
	assign pop       = (rem_q != 3'd0) && (!out_valid_q || dout.ready);
	assign din.ready = (rem_q == 3'd0) || (rem_q == 3'd1 && pop);
	assign acc       = din.valid && din.ready;

	// Pending decode code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (acc) begin
			pend_q <= pend_nxt;
		end
	end

	// Run buffer: load on accept, advance on each pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (acc) begin
			rem_q <= run.count;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			chars_q <= run.chars;
		end else if (pop) begin
			for (int k = 0; k < RunDepth - 1; k++) begin
				chars_q[k] <= chars_q[k+1];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_char_q <= chars_q[0];
			out_last_q <= (rem_q == 3'd1);
		end
	end

	assign dout.valid       = out_valid_q;
	assign dout.out_char    = out_char_q;
	assign dout.last_of_run = out_last_q;

	// A transaction with results leaves them in the run buffer
	a_run_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		acc && run.count != 3'd0 |=> rem_q != 3'd0)
		else $error("run buffer empty after accepting a transaction with results");

	// No new transaction while more than one result is still buffered
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q > 3'd1 |-> !din.ready)
		else $error("input ready while run buffer still busy");

	// Encoding never disturbs the pending decode code
	a_encode_keeps_pending: assert property (@(posedge clk) disable iff (!arst_n)
		acc && dir_q == DirEncode |=> $stable(pend_q))
		else $error("pending code changed in encode mode");

	// Decode never yields more than two results per transaction
	a_decode_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc && dir_q == DirDecode |-> run.count <= 3'd2)
		else $error("decode transaction produced too many results");

endmodule
`default_nettype wire
